>>> rtl/pcl_pkg.sv
// Package for the command line parser: transfer types, character codes and keyword table.
`default_nettype none

package pcl_pkg;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [3:0]  command_class;
      logic        has_payload;
      logic [7:0]  parameter_count;
      logic [30:0] transaction_id;
      logic [30:0] payload_length;
   } rsp_type;

   localparam logic [7:0]  SPACE_CHAR   = 8'h20;
   localparam logic [7:0]  DIGIT_ZERO   = 8'h30;
   localparam logic [7:0]  DIGIT_NINE   = 8'h39;
   localparam logic [30:0] VALUE_MAX    = 31'h7FFF_FFFF;
   localparam logic [3:0]  CLASS_OTHER  = 4'd0;
   localparam logic [3:0]  CLASS_DIGITS = 4'd14;
   localparam int          NUM_KEYWORDS = 13;

   // keywords packed first character in the low byte, unused bytes zero
   localparam logic [31:0] KEYWORDS [NUM_KEYWORDS] = '{
      32'h004C_4441,   // ADL
      32'h0046_4347,   // GCF
      32'h0000_4753,   // SG
      32'h0047_534D,   // MSG
      32'h004C_4D52,   // RML
      32'h0058_4255,   // UBX
      32'h004E_4255,   // UBN
      32'h004D_5555,   // UUM
      32'h004D_4255,   // UBM
      32'h0059_5146,   // FQY
      32'h004E_5555,   // UUN
      32'h0058_5555,   // UUX
      32'h0047_5049    // IPG
   };

endpackage

`default_nettype wire

>>> rtl/protocol_command_line_parser.sv
// Command line parser top level: splits a byte stream into command word and parameters.
// Result: registered in the output register, or in the skid slot while that one is full.
// Throughput: one byte per cycle while the skid slot is empty; the byte update and the line
//    summary are one pass of logic between the line state registers and the output register.
// Reset: synchronous, active high; clears the line state and both output slots.
`default_nettype none

module protocol_command_line_parser #(
   parameter int MAX_PARAMS = 255
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire pcl_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      pcl_pkg::rsp_type rsp_data
);
   import pcl_pkg::*;

   // field counter holds 0 (command word) up to MAX_PARAMS + 1, where it sticks
   localparam int FW      = $clog2(MAX_PARAMS + 2);
   localparam int CAP     = (MAX_PARAMS < 255) ? MAX_PARAMS : 255;
   localparam int FIELD_TOP = MAX_PARAMS + 1;

   // ---------------------------------------------------------------
   // Line state
   // ---------------------------------------------------------------
   logic [FW-1:0] field_number_ff, field_number_in;
   logic [31:0]   command_chars_ff, command_chars_in;
   logic [2:0]    command_length_ff, command_length_in;
   logic          command_all_digits_ff, command_all_digits_in;
   logic [30:0]   first_value_ff, first_value_in;
   logic          first_numeric_ff, first_numeric_in;
   logic [30:0]   current_value_ff, current_value_in;
   logic          current_numeric_ff, current_numeric_in;

   // output register plus a skid slot, so a single waiting result does not block the next byte
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_data_ff, out_data_in;
   logic          skid_valid_ff, skid_valid_in;
   rsp_type       skid_data_ff, skid_data_in;

   logic          req_fire;
   logic          produce;
   logic          take;
   logic          is_space;
   logic          is_digit;
   logic [34:0]   times_ten;
   logic [30:0]   digit_sum;
   logic          empty_rest;
   logic [3:0]    cls;
   rsp_type       result;

   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !req_stall;
   assign produce   = req_fire && req_data.line_end;
   assign take      = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign is_space = (req_data.line_byte == SPACE_CHAR);
   assign is_digit = (req_data.line_byte >= DIGIT_ZERO) && (req_data.line_byte <= DIGIT_NINE);

   // value * 10 + digit, saturating
   assign times_ten = {1'b0, current_value_ff, 3'b000} + {3'b000, current_value_ff, 1'b0}
                      + {31'd0, req_data.line_byte[3:0] - DIGIT_ZERO[3:0]};
   assign digit_sum = (times_ten > {4'd0, VALUE_MAX}) ? VALUE_MAX : times_ten[30:0];

   // ---------------------------------------------------------------
   // Per-byte update of the line state
   // ---------------------------------------------------------------
   always_comb begin
      field_number_in       = field_number_ff;
      command_chars_in      = command_chars_ff;
      command_length_in     = command_length_ff;
      command_all_digits_in = command_all_digits_ff;
      first_value_in        = first_value_ff;
      first_numeric_in      = first_numeric_ff;
      current_value_in      = current_value_ff;
      current_numeric_in    = current_numeric_ff;

      if (is_space) begin
         if (field_number_ff == FW'(1)) begin
            first_value_in   = current_value_ff;
            first_numeric_in = current_numeric_ff;
         end
         if (field_number_ff < FW'(FIELD_TOP)) begin
            field_number_in = field_number_ff + FW'(1);
         end
         current_value_in   = '0;
         current_numeric_in = 1'b1;
      end else if (field_number_ff == '0) begin
         if (command_length_ff < 3'd4) begin
            command_chars_in  = command_chars_ff
                                | ({24'd0, req_data.line_byte} << {command_length_ff[1:0], 3'b000});
            command_length_in = command_length_ff + 3'd1;
         end
         if (!is_digit) begin
            command_all_digits_in = 1'b0;
         end
      end else begin
         if (is_digit) begin
            if (current_numeric_ff) begin
               current_value_in = digit_sum;
            end
         end else begin
            current_numeric_in = 1'b0;
            current_value_in   = '0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Line summary, taken from the state as updated by the last byte
   // ---------------------------------------------------------------
   always_comb begin
      cls = command_all_digits_in ? CLASS_DIGITS : CLASS_OTHER;
      // a keyword only ever has one to three characters; later hits lose to earlier
      if ((command_length_in >= 3'd1) && (command_length_in <= 3'd3)) begin
         for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
            if (command_chars_in == KEYWORDS[k]) begin
               cls = 4'(k + 1);
            end
         end
      end

      // a single space closing the line leaves an empty rest: no parameters
      empty_rest = (field_number_in == FW'(1)) && is_space;

      result                 = '0;
      result.command_class   = cls;
      result.has_payload     = (cls != CLASS_OTHER);
      if ((field_number_in != '0) && !empty_rest) begin
         result.parameter_count = (field_number_in > FW'(CAP)) ? 8'(CAP)
                                                               : 8'(field_number_in);
         if (field_number_in == FW'(1)) begin
            result.transaction_id = current_numeric_in ? current_value_in : '0;
         end else begin
            result.transaction_id = first_numeric_in ? first_value_in : '0;
         end
         if ((cls != CLASS_OTHER) && current_numeric_in) begin
            result.payload_length = current_value_in;
         end
      end
   end

   // ---------------------------------------------------------------
   // Output slots
   // ---------------------------------------------------------------
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // input is stalled while the skid slot is full
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (produce) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || produce) begin
         // each line starts from the reset state
         field_number_ff       <= '0;
         command_chars_ff      <= '0;
         command_length_ff     <= '0;
         command_all_digits_ff <= 1'b1;
         first_value_ff        <= '0;
         first_numeric_ff      <= 1'b1;
         current_value_ff      <= '0;
         current_numeric_ff    <= 1'b1;
      end else if (req_fire) begin
         field_number_ff       <= field_number_in;
         command_chars_ff      <= command_chars_in;
         command_length_ff     <= command_length_in;
         command_all_digits_ff <= command_all_digits_in;
         first_value_ff        <= first_value_in;
         first_numeric_ff      <= first_numeric_in;
         current_value_ff      <= current_value_in;
         current_numeric_ff    <= current_numeric_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef ASSERT_OFF
   // skid slot only fills behind a waiting result
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot full with output register empty");

   // after a finished line the output register always holds a result
   assert property (@(posedge clock) disable iff (reset)
      produce |=> out_valid_ff)
      else $error("line end transfer gave no result");

   // line state is back at its start after the last byte
   assert property (@(posedge clock) disable iff (reset)
      produce |=> (field_number_ff == '0) && (command_length_ff == '0))
      else $error("line state not cleared after line end");

   // payload flag follows the class
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff.has_payload == (out_data_ff.command_class != CLASS_OTHER)))
      else $error("has_payload inconsistent with command_class");
`endif

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Testbench for the command line parser: random and directed lines against a built-in line model.
`timescale 1ns / 100ps

module testbench;
   import pcl_pkg::*;

   localparam int MAX_FIELDS   = 255;
   localparam int QUIET_LIMIT  = 3000;   // cycles with no transfer on either side
   localparam int HOLD_CYCLES  = 300;    // long receiver hold-off for the pressure test
   localparam int TAIL_CYCLES  = 10;
   localparam int REPORT_LIMIT = 200;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    req_valid  = 1'b0;
   logic    req_stall;
   req_type req_data   = '0;
   logic    rsp_valid;
   logic    rsp_stall  = 1'b0;
   rsp_type rsp_data;

   protocol_command_line_parser #(
      .MAX_PARAMS(MAX_FIELDS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Keyword spellings, in class order (class = index + 1).
   string keyword_list [13] = '{"ADL", "GCF", "SG", "MSG", "RML", "UBX", "UBN",
                                "UUM", "UBM", "FQY", "UUN", "UUX", "IPG"};

   // Line model state: mirrors what the parser keeps between bytes of one line.
   logic [8:0]  field_num;
   logic [31:0] word_chars;
   logic [2:0]  word_len;
   logic        word_digits;
   logic [30:0] first_val;
   logic        first_num;
   logic [30:0] cur_val;
   logic        cur_num;

   rsp_type     pending_summaries[$];   // line summaries still to come out, oldest first
   rsp_type     summary_due;
   logic [7:0]  line_text[$];           // line being built by the stimulus

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;
   int bytes_sent     = 0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;

   // ---------------------------------------------------------------- line model

   function automatic void clear_line_state();
      field_num   = '0;
      word_chars  = '0;
      word_len    = '0;
      word_digits = 1'b1;
      first_val   = '0;
      first_num   = 1'b1;
      cur_val     = '0;
      cur_num     = 1'b1;
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= DIGIT_ZERO && b <= DIGIT_NINE;
   endfunction

   // value * 10 + digit, pinned at the 31-bit maximum
   function automatic logic [30:0] append_digit(input logic [30:0] v, input logic [7:0] b);
      logic [35:0] n;
      n = 36'(v) * 36'd10 + 36'(b - DIGIT_ZERO);
      return (n > 36'(VALUE_MAX)) ? VALUE_MAX : n[30:0];
   endfunction

   // Keyword spelling packed first character low, unused bytes zero.
   function automatic logic [31:0] keyword_code(input int k);
      string       s;
      logic [31:0] code;
      s    = keyword_list[k];
      code = '0;
      for (int i = 0; i < s.len(); i++)
         code |= 32'(s[i]) << (8 * i);
      return code;
   endfunction

   // Folds one transferred byte into the line state; on the last byte of a line
   // it queues the summary the parser should give and starts a fresh line.
   function automatic void fold_byte(input logic [7:0] b, input logic last);
      rsp_type    s;
      logic [3:0] cls;
      logic       empty_rest;
      if (b == SPACE_CHAR) begin
         if (field_num == 9'd1) begin
            first_val = cur_val;
            first_num = cur_num;
         end
         if (field_num < 9'(MAX_FIELDS + 1))
            field_num++;
         cur_val = '0;
         cur_num = 1'b1;
      end else if (field_num == '0) begin
         if (word_len < 3'd4) begin
            word_chars |= 32'(b) << (8 * word_len);
            word_len++;
         end
         if (!is_digit(b))
            word_digits = 1'b0;
      end else if (is_digit(b)) begin
         if (cur_num)
            cur_val = append_digit(cur_val, b);
      end else begin
         cur_num = 1'b0;
         cur_val = '0;
      end
      if (!last)
         return;

      // a word of four or more characters never names a keyword
      cls = word_digits ? CLASS_DIGITS : CLASS_OTHER;
      if (word_len >= 3'd1 && word_len <= 3'd3) begin
         for (int k = 12; k >= 0; k--)
            if (word_chars == keyword_code(k))
               cls = 4'(k + 1);
      end

      // a lone space closing the line leaves nothing after it: no fields
      empty_rest = (field_num == 9'd1) && (b == SPACE_CHAR);
      s = '0;
      s.command_class = cls;
      s.has_payload   = (cls != CLASS_OTHER);
      if (field_num >= 9'd1 && !empty_rest) begin
         s.parameter_count = (field_num > 9'(MAX_FIELDS)) ? 8'(MAX_FIELDS) : field_num[7:0];
         if (field_num == 9'd1)
            s.transaction_id = cur_num ? cur_val : '0;
         else
            s.transaction_id = first_num ? first_val : '0;
         if (cls != CLASS_OTHER && cur_num)
            s.payload_length = cur_val;
      end
      pending_summaries.push_back(s);
      clear_line_state();
   endfunction

   // ---------------------------------------------------------------- line builders

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++)
         line_text.push_back(s[i]);
   endfunction

   function automatic void add_digits(input int n);
      repeat (n) line_text.push_back(8'(DIGIT_ZERO + $urandom_range(9)));
   endfunction

   // Mostly well-formed lines (keyword, numeric fields) with some broken words,
   // odd bytes and the odd line of pure noise.
   function automatic void compose_line();
      int w, k, n, c;
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 10)) line_text.push_back(8'($urandom_range(255)));
         return;
      end
      w = $urandom_range(99);
      k = $urandom_range(12);
      if (w < 55)
         put_text(keyword_list[k]);
      else if (w < 65)
         add_digits($urandom_range(1, 5));
      else if (w < 72) begin
         // empty command word
      end else if (w < 80) begin
         put_text(keyword_list[k]);
         line_text.push_back(8'($urandom_range(33, 126)));
      end else if (w < 86) begin
         // a zero byte after the keyword: still matches for two-letter words
         put_text(keyword_list[k]);
         line_text.push_back(8'h00);
      end else if (w < 92) begin
         put_text(keyword_list[k]);
         line_text[$urandom_range(line_text.size() - 1)] = 8'($urandom_range(33, 126));
      end else
         repeat ($urandom_range(1, 6)) line_text.push_back(8'($urandom_range(255)));

      n = ($urandom_range(99) < 20) ? 0 : $urandom_range(1, 6);
      if (n == 0 && $urandom_range(1))
         line_text.push_back(SPACE_CHAR);
      for (int i = 0; i < n; i++) begin
         line_text.push_back(SPACE_CHAR);
         c = $urandom_range(99);
         if (c < 45)
            add_digits($urandom_range(0, 4));
         else if (c < 55)
            add_digits($urandom_range(9, 12));       // near or past saturation
         else if (c < 65) begin
            // empty field
         end else if (c < 85)
            repeat ($urandom_range(1, 4))
               line_text.push_back($urandom_range(1) ? 8'(DIGIT_ZERO + $urandom_range(9))
                                                     : 8'(8'h41 + $urandom_range(25)));
         else
            repeat ($urandom_range(1, 4)) line_text.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(9) == 0)
         line_text.push_back(SPACE_CHAR);
      if (line_text.size() == 0)
         add_digits(1);
   endfunction

   // ---------------------------------------------------------------- driving

   // One byte transfer; optional idle cycles first, then hold until taken.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= '{line_byte: b, line_end: last};
      do @(posedge clock); while (req_stall);
      fold_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_line();
      for (int i = 0; i < line_text.size(); i++)
         send_byte(line_text[i], i == line_text.size() - 1);
      line_text.delete();
   endtask

   task automatic run_random_lines(input int budget);
      int target;
      target = bytes_sent + budget;
      while (bytes_sent < target) begin
         compose_line();
         send_line();
      end
   endtask

   // Receiver: random stalls, or a long counted hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what);
      if (mismatch_count < REPORT_LIMIT)
         $display("%0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0d, should be %0d", name, got, want));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_summaries.size() == 0)
            report_mismatch("summary transfer with no line outstanding");
         else begin
            summary_due = pending_summaries.pop_front();
            compare_field("command_class",   32'(rsp_data.command_class),
                          32'(summary_due.command_class));
            compare_field("has_payload",     32'(rsp_data.has_payload),
                          32'(summary_due.has_payload));
            compare_field("parameter_count", 32'(rsp_data.parameter_count),
                          32'(summary_due.parameter_count));
            compare_field("transaction_id",  32'(rsp_data.transaction_id),
                          32'(summary_due.transaction_id));
            compare_field("payload_length",  32'(rsp_data.payload_length),
                          32'(summary_due.payload_length));
         end
      end
   end

   // Watchdog: a long run of cycles with no transfer means the parser has hung.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // Short hand-picked lines: lone space, zero and all-ones bytes, keyword with
   // no fields, keyword with a zero byte after it, trailing space, saturation.
   task automatic test_directed_lines();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      put_text(" ");
      send_line();
      line_text = '{8'h00};
      send_line();
      line_text = '{8'hFF};
      send_line();
      put_text("SG");
      send_line();
      put_text("SG");
      line_text.push_back(8'h00);
      send_line();
      put_text("FQY 7 ");
      send_line();
      put_text("UBX 99999999999");
      send_line();
   endtask

   task automatic test_back_to_back();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random_lines(250);
   endtask

   task automatic test_sender_gaps();
      send_idle_pct  = 80;
      recv_stall_pct = 0;
      run_random_lines(250);
   endtask

   task automatic test_receiver_stalls();
      send_idle_pct  = 0;
      recv_stall_pct = 80;
      run_random_lines(250);
   endtask

   task automatic test_mixed_idling();
      send_idle_pct  = 11;
      recv_stall_pct = 11;
      run_random_lines(250);
   endtask

   // A single line with many fields, at times more than the count can show; first and last field
   // must still be picked out exactly.
   task automatic test_field_saturation();
      send_idle_pct  = 0;
      recv_stall_pct = 11;
      repeat (1) begin
         put_text(keyword_list[$urandom_range(12)]);
         repeat ($urandom_range(250, 300)) begin
            line_text.push_back(SPACE_CHAR);
            if ($urandom_range(9) < 3)
               add_digits(1);
         end
         line_text.push_back(SPACE_CHAR);
         add_digits($urandom_range(1, 3));
         send_line();
      end
   endtask

   // Receiver holds off for a long stretch while lines keep coming, so the
   // parser fills up and has to stall its input.
   task automatic test_output_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = HOLD_CYCLES;
      run_random_lines(150);
   endtask

   initial begin
      clear_line_state();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_lines();
      test_back_to_back();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idling();
      test_field_saturation();
      test_output_backpressure();

      @(negedge clock);
      req_valid <= 1'b0;
      recv_stall_pct = 0;
      while (pending_summaries.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
